>>> sv/rlt_pkg.sv
`default_nettype none
package rlt_pkg;
	localparam int MaxSlots = 64;
	localparam int SlotW = $clog2(MaxSlots);
	localparam int KeyBytes = 256;
	localparam int KeyKeep = KeyBytes - 1;
	localparam int LenW = $clog2(KeyBytes);
	localparam int HoldW = 16;
	localparam logic [31:0] HashSeed = 32'd5381;
	localparam logic [HoldW-1:0] HoldMax = '1;
	localparam int SlotRecW = 1 + LenW + HoldW;

	typedef enum logic [2:0] {
		ST_JOINED = 3'd0,
		ST_NEW    = 3'd1,
		ST_FULL   = 3'd2,
		ST_HELD   = 3'd3,
		ST_FREED  = 3'd4,
		ST_IDLE   = 3'd5
	} status_t;

	typedef struct packed {
		logic       action;
		logic [7:0] key_byte;
		logic       key_last;
		logic [5:0] release_slot;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [5:0]  slot_index;
		logic [15:0] holders;
	} out_item_t;

	typedef struct packed {
		logic             busy;
		logic [LenW-1:0]  len;
		logic [HoldW-1:0] holders;
	} slot_rec_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MOD,
		S_RD,
		S_CHK,
		S_CMP_RD,
		S_CMP,
		S_COPY_RD,
		S_COPY_WR,
		S_REL_RD,
		S_REL,
		S_OUT
	} fsm_t;
endpackage
`default_nettype wire

>>> sv/rlt_ram.sv
`default_nettype none
module rlt_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

>>> sv/refcounted_lock_table.sv
// Key bytes: accepted back to back while idle; only the last byte of an acquire yields a result.
// Acquire: serial hash remainder, then a read and check per probed slot, a read and compare
// per key byte, a reread of a matched slot, a read and write per copied byte, then the load.
// Release: the item passes S_REL_RD, S_REL and S_OUT, then the block returns to S_IDLE.
// One item in flight; a waiting result holds the next item in S_OUT, which also stalls the input.
// Reset (arst_n low) starts a pass that clears all slot records; input stalls meanwhile.
`default_nettype none
module refcounted_lock_table import rlt_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire in_item_t  in_data,
	output logic           out_valid,
	input  wire logic      out_stall,
	output out_item_t      out_data,
	input  wire logic      cfg_valid,
	output logic           cfg_ready,
	input  wire logic [6:0] cfg_data
);
	fsm_t state_q, state_d;
	logic [6:0] slots_q;
	logic [LenW-1:0] plen_q;
	logic [31:0] hash_q;
	logic [SlotW-1:0] idx_q, first_q;
	logic [SlotW:0] tries_q, clr_q;
	logic [LenW-1:0] pos_q;
	logic [SlotW:0] n_eff;
	logic [31:0] rem_q;
	logic [SlotW+1:0] mod_cnt_q;
	logic [SlotW+1:0] mod_step;
	out_item_t res_q;
	in_item_t rel_q;
	// matched_q: key fully matched, next S_CHK just increments
	logic matched_q;

	// memories
	logic pk_we; logic [LenW-1:0] pk_wa, pk_ra; logic [7:0] pk_wd, pk_rd;
	logic sk_we; logic [SlotW+LenW-1:0] sk_wa, sk_ra; logic [7:0] sk_wd, sk_rd;
	logic sr_we; logic [SlotW-1:0] sr_wa, sr_ra; slot_rec_t sr_wd, sr_rd;

	rlt_ram #(.Width(8), .Depth(KeyBytes)) u_pk (.clk, .we(pk_we), .waddr(pk_wa),
		.wdata(pk_wd), .raddr(pk_ra), .rdata(pk_rd));
	rlt_ram #(.Width(8), .Depth(MaxSlots*KeyBytes)) u_sk (.clk, .we(sk_we), .waddr(sk_wa),
		.wdata(sk_wd), .raddr(sk_ra), .rdata(sk_rd));
	rlt_ram #(.Width(SlotRecW), .Depth(MaxSlots)) u_sr (.clk, .we(sr_we), .waddr(sr_wa),
		.wdata(sr_wd), .raddr(sr_ra), .rdata(sr_rd));

	always_comb begin
		if (slots_q == '0) n_eff = (SlotW+1)'(1);
		else if (32'(slots_q) > 32'(MaxSlots)) n_eff = (SlotW+1)'(MaxSlots);
		else n_eff = (SlotW+1)'(slots_q);
	end

	// one restoring step of the remainder
	always_comb begin
		mod_step = {1'b0, first_q, rem_q[31]};
		if (mod_step >= (SlotW+2)'(n_eff)) mod_step = mod_step - (SlotW+2)'(n_eff);
	end

	logic clearing;
	assign clearing = clr_q != '0;
	assign in_stall = (state_q != S_IDLE) || clearing;
	assign cfg_ready = (state_q == S_IDLE);
	logic in_acc;
	assign in_acc = in_valid && !in_stall;
	logic out_free;
	assign out_free = !out_valid || !out_stall;
	logic match_now;
	assign match_now = sr_rd.busy && sr_rd.len == plen_q;
	logic [SlotW-1:0] idx_nx;
	assign idx_nx = ({1'b0, idx_q} + 1'b1 >= n_eff) ? '0 : idx_q + 1'b1;
	slot_rec_t rel_rec;
	always_comb begin
		rel_rec = sr_rd;
		if (rel_rec.holders != '0) rel_rec.holders = rel_rec.holders - 1'b1;
		if (rel_rec.holders == '0) begin
			rel_rec.busy = 1'b0;
			rel_rec.len = '0;
		end
	end

	always_comb begin
		state_d = state_q;
		pk_we = 1'b0; pk_wa = plen_q; pk_wd = in_data.key_byte; pk_ra = pos_q;
		sk_we = 1'b0; sk_wa = {idx_q, pos_q}; sk_wd = pk_rd; sk_ra = {idx_q, pos_q};
		sr_we = 1'b0; sr_wa = idx_q; sr_wd = sr_rd; sr_ra = idx_q;
		if (clearing) begin
			sr_we = 1'b1;
			sr_wa = clr_q[SlotW-1:0] - 1'b1;
			sr_wd = '0;
		end
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					if (in_data.action) begin
						state_d = S_REL_RD;
					end else begin
						pk_we = 32'(plen_q) < KeyKeep;
						if (in_data.key_last) state_d = S_MOD;
					end
				end
			end
			S_MOD: if (mod_cnt_q == '0) state_d = S_RD;
			S_RD: state_d = S_CHK;
			S_CHK: begin
				if (match_now) begin
					if (plen_q == '0 || matched_q) begin
						sr_we = 1'b1;
						if (sr_rd.holders != HoldMax) sr_wd.holders = sr_rd.holders + 1'b1;
						state_d = S_OUT;
					end else state_d = S_CMP_RD;
				end else if (!sr_rd.busy) begin
					sr_we = 1'b1;
					sr_wd.busy = 1'b1; sr_wd.len = plen_q; sr_wd.holders = HoldW'(1);
					state_d = (plen_q == '0) ? S_OUT : S_COPY_RD;
				end else if (tries_q + 1'b1 >= n_eff) state_d = S_OUT;
				else state_d = S_RD;
				sr_ra = idx_q;
			end
			S_CMP_RD: state_d = S_CMP;
			S_CMP: begin
				if (pk_rd != sk_rd) begin
					state_d = (tries_q + 1'b1 >= n_eff) ? S_OUT : S_RD;
				end else if (pos_q + 1'b1 == plen_q) begin
					state_d = S_RD; // reread record to increment
				end else state_d = S_CMP_RD;
			end
			S_COPY_RD: state_d = S_COPY_WR;
			S_COPY_WR: begin
				sk_we = 1'b1;
				state_d = (pos_q + 1'b1 == plen_q) ? S_OUT : S_COPY_RD;
			end
			S_REL_RD: begin
				sr_ra = rel_q.release_slot;
				state_d = S_REL;
			end
			S_REL: begin
				sr_wa = rel_q.release_slot;
				sr_wd = rel_rec;
				sr_we = sr_rd.busy;
				state_d = S_OUT;
			end
			// hold while the previous result still waits
			S_OUT: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			slots_q <= 7'd64;
			plen_q <= '0;
			hash_q <= HashSeed;
			clr_q <= (SlotW+1)'(MaxSlots);
			out_valid <= 1'b0;
			matched_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clearing) clr_q <= clr_q - 1'b1;
			if (cfg_valid && cfg_ready) slots_q <= cfg_data;
			if (state_q == S_OUT && out_free) out_valid <= 1'b1;
			else if (out_valid && !out_stall) out_valid <= 1'b0;
			if (state_q == S_IDLE && in_acc && !in_data.action
			    && 32'(plen_q) < KeyKeep) begin
				plen_q <= plen_q + 1'b1;
				hash_q <= (hash_q << 5) + hash_q + 32'(in_data.key_byte);
			end
			if (state_q == S_CMP && pk_rd == sk_rd && pos_q + 1'b1 == plen_q)
				matched_q <= 1'b1;
			if (state_q == S_OUT && out_free) begin
				matched_q <= 1'b0;
				if (!rel_q.action) begin
					plen_q <= '0;
					hash_q <= HashSeed;
				end
			end
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		if (in_acc) begin
			rel_q <= in_data;
			tries_q <= '0;
			res_q <= '{status: ST_FULL, slot_index: '0, holders: '0};
			if (32'(plen_q) < KeyKeep) rem_q <= (hash_q << 5) + hash_q + 32'(in_data.key_byte);
			else rem_q <= hash_q;
			mod_cnt_q <= (SlotW+2)'(32);
			first_q <= '0;
		end
		// restoring remainder, one bit per cycle; first_q holds partial remainder
		if (state_q == S_MOD) begin
			rem_q <= rem_q << 1;
			first_q <= mod_step[SlotW-1:0];
			mod_cnt_q <= mod_cnt_q - 1'b1;
			if (mod_cnt_q == (SlotW+2)'(1)) idx_q <= mod_step[SlotW-1:0];
		end
		if (state_q == S_CHK) begin
			pos_q <= '0;
			if (match_now && (plen_q == '0 || matched_q)) begin
				res_q <= '{status: ST_JOINED, slot_index: 6'(idx_q),
					holders: (sr_rd.holders != HoldMax) ? sr_rd.holders + 1'b1 : sr_rd.holders};
			end else if (!sr_rd.busy) begin
				res_q <= '{status: ST_NEW, slot_index: 6'(idx_q), holders: 16'd1};
			end else if (!match_now) begin
				tries_q <= tries_q + 1'b1;
				idx_q <= idx_nx;
			end
		end
		if (state_q == S_CMP) begin
			pos_q <= pos_q + 1'b1;
			if (pk_rd != sk_rd) begin
				tries_q <= tries_q + 1'b1;
				idx_q <= idx_nx;
			end
		end
		if (state_q == S_COPY_WR) pos_q <= pos_q + 1'b1;
		if (state_q == S_REL) begin
			if (!sr_rd.busy)
				res_q <= '{status: ST_IDLE, slot_index: rel_q.release_slot, holders: '0};
			else if (rel_rec.busy)
				res_q <= '{status: ST_HELD, slot_index: rel_q.release_slot,
					holders: rel_rec.holders};
			else
				res_q <= '{status: ST_FREED, slot_index: rel_q.release_slot, holders: '0};
		end
		if (state_q == S_OUT && out_free) out_data <= res_q;
	end

	ap_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall) else $error("input taken while busy");
	ap_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_data)))
		else $error("stalled result changed");
	ap_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> state_q == S_IDLE) else $error("work during clearing pass");
endmodule
`default_nettype wire
